// ===== design/lagrange_interp_nonuniform_assert.svh =====
// Assertion macros for the Lagrange interpolation block.
`ifndef LAGRANGE_INTERP_NONUNIFORM_ASSERT_SVH
`define LAGRANGE_INTERP_NONUNIFORM_ASSERT_SVH
`ifndef SYNTH
`define LGI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lgi assertion failed");
`define LGI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lgi assertion failed");
`else
`define LGI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LGI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/lgi_pkg.sv =====
// Shared types and constants of the Lagrange interpolation block.
package lgi_pkg;

    localparam int LGI_MAX_KNOTS = 64;
    localparam int MIN_KNOTS     = 3;
    localparam int WIDE_W        = 128;
    localparam int FAC_W         = 33;
    localparam int QUO_W         = 64;

    localparam logic [WIDE_W-1:0] TERM_LIMIT = 128'h1 << 60;
    localparam logic signed [QUO_W-1:0] RES_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [QUO_W-1:0] RES_MIN = -64'sh0000_0000_8000_0000;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ORDER = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;

    localparam logic [2:0] PTS3 = 3'd3;
    localparam logic [2:0] PTS4 = 3'd4;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         knot_slot;
        logic signed [31:0] knot_pos;
        logic signed [31:0] knot_val;
        logic signed [31:0] query_pos;
        logic [1:0]         deriv_order;
    } lgi_in_t;

    typedef struct packed {
        logic signed [31:0] interp_result;
        logic [1:0]         status;
    } lgi_out_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] val;
    } knot_entry_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_DIV = 2'd2
    } alu_op_e;

    typedef struct packed {
        logic    start;
        alu_op_e op;
    } alu_cmd_t;

    typedef struct packed {
        logic done;
        logic sat;
    } alu_sts_t;

endpackage

// ===== design/lgi_knot_mem.sv =====
// Knot table: one position/value pair per slot, one write and one registered read port.
module lgi_knot_mem import lgi_pkg::*; #(
    parameter int MAX_KNOTS = LGI_MAX_KNOTS,
    parameter int AW        = $clog2(MAX_KNOTS)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  knot_entry_t   wr_data,
    input  logic [AW-1:0] rd_addr,
    output knot_entry_t   rd_data
);

    knot_entry_t mem [MAX_KNOTS];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/lgi_alu.sv =====
// Shared 128-bit arithmetic unit: serial multiply, registered add, restoring divide.
module lgi_alu import lgi_pkg::*; (
    input  logic                    clk,
    input  logic                    rstn,
    input  alu_cmd_t                cmd,
    input  logic [WIDE_W-1:0]       opa,
    input  logic signed [FAC_W-1:0] fac,
    input  logic [WIDE_W-1:0]       opd,
    output alu_sts_t                sts,
    output logic [WIDE_W-1:0]       prod,
    output logic signed [QUO_W-1:0] quot
);

    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_MUL  = 8'b0000_0010,
        PH_NEGN = 8'b0000_0100,
        PH_NEGD = 8'b0000_1000,
        PH_DIV  = 8'b0001_0000,
        PH_RND  = 8'b0010_0000,
        PH_INC  = 8'b0100_0000,
        PH_FIN  = 8'b1000_0000
    } phase_e;

    phase_e ph_reg, ph_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] opa_reg, opa_next;
    logic [FAC_W-1:0]  fac_reg, fac_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              rup_reg, rup_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;
    logic signed [QUO_W-1:0] quo_reg, quo_next;

    logic [WIDE_W-1:0] add_x, add_y;
    logic              add_sub, add_cin;
    logic [WIDE_W:0]   add_full;
    logic              add_carry;
    logic [WIDE_W-1:0] mag;
    logic              over;

    // The one adder of the unit; with add_sub it subtracts, and its carry is "x >= y".
    assign add_full  = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + {{WIDE_W{1'b0}}, (add_sub | add_cin)};
    assign add_carry = add_full[WIDE_W];

    assign over = acc_reg > TERM_LIMIT;
    assign mag  = over ? TERM_LIMIT : acc_reg;

    always_comb begin
        add_x   = opa;
        add_y   = opd;
        add_sub = 1'b0;
        add_cin = 1'b0;
        unique case (ph_reg)
            PH_IDLE: begin
                add_x = opa;
                add_y = opd;
            end
            PH_MUL: begin
                add_x   = acc_reg;
                add_y   = opa_reg;
                add_sub = cnt_reg == 7'(FAC_W - 1);
            end
            PH_NEGN: begin
                add_x   = '0;
                add_y   = opa_reg;
                add_sub = opa_reg[WIDE_W-1];
            end
            PH_NEGD: begin
                add_x   = '0;
                add_y   = den_reg;
                add_sub = den_reg[WIDE_W-1];
            end
            PH_DIV: begin
                add_x   = {rem_reg[WIDE_W-2:0], opa_reg[WIDE_W-1]};
                add_y   = den_reg;
                add_sub = 1'b1;
            end
            PH_RND: begin
                add_x   = {rem_reg[WIDE_W-2:0], 1'b0};
                add_y   = den_reg;
                add_sub = 1'b1;
            end
            PH_INC: begin
                add_x   = acc_reg;
                add_y   = '0;
                add_cin = rup_reg;
            end
            PH_FIN: begin
                add_x = acc_reg;
                add_y = '0;
            end
            default: begin
                add_x = opa;
            end
        endcase
    end

    always_comb begin
        ph_next   = ph_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        fac_next  = fac_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rup_next  = rup_reg;
        sat_next  = sat_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE: begin
                if (cmd.start) begin
                    sat_next = 1'b0;
                    cnt_next = '0;
                    unique case (cmd.op)
                        OP_MUL: begin
                            acc_next = '0;
                            opa_next = opa;
                            fac_next = fac;
                            ph_next  = PH_MUL;
                        end
                        OP_ADD: begin
                            acc_next  = add_full[WIDE_W-1:0];
                            done_next = 1'b1;
                        end
                        OP_DIV: begin
                            opa_next = opa;
                            den_next = opd;
                            neg_next = opa[WIDE_W-1] ^ opd[WIDE_W-1];
                            ph_next  = PH_NEGN;
                        end
                        default: begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            PH_MUL: begin
                // Bit 32 of the factor carries negative weight.
                if (fac_reg[0]) begin
                    acc_next = add_full[WIDE_W-1:0];
                end
                opa_next = {opa_reg[WIDE_W-2:0], 1'b0};
                fac_next = {1'b0, fac_reg[FAC_W-1:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(FAC_W - 1)) begin
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
            end
            PH_NEGN: begin
                opa_next = add_full[WIDE_W-1:0];
                ph_next  = PH_NEGD;
            end
            PH_NEGD: begin
                den_next = add_full[WIDE_W-1:0];
                rem_next = '0;
                acc_next = '0;
                cnt_next = '0;
                ph_next  = PH_DIV;
            end
            PH_DIV: begin
                rem_next = add_carry ? add_full[WIDE_W-1:0] : add_x;
                acc_next = {acc_reg[WIDE_W-2:0], add_carry};
                opa_next = {opa_reg[WIDE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(WIDE_W - 1)) begin
                    ph_next = PH_RND;
                end
            end
            PH_RND: begin
                // Round half away from zero: bump when twice the remainder reaches the divisor.
                rup_next = add_carry;
                ph_next  = PH_INC;
            end
            PH_INC: begin
                acc_next = add_full[WIDE_W-1:0];
                ph_next  = PH_FIN;
            end
            PH_FIN: begin
                sat_next  = over;
                quo_next  = neg_reg ? -$signed(mag[QUO_W-1:0]) : $signed(mag[QUO_W-1:0]);
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default: begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        fac_reg <= fac_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        rup_reg <= rup_next;
        sat_reg <= sat_next;
        quo_reg <= quo_next;
    end

    assign sts.done = done_reg;
    assign sts.sat  = sat_reg;
    assign prod     = acc_reg;
    assign quot     = quo_reg;

endmodule

// ===== design/lagrange_interp_nonuniform.sv =====
// Top level of the piecewise Lagrange interpolator over a nonuniform knot table.
//
// A load transfer writes one knot (position, value) into the table and gives no result.
// A query transfer gives one result: the value (order 0) or slope (order 1) at the query
// position, signed Q16.16, with status 0 ok, 1 bad order, 2 saturated or zero knot
// spacing. A bad order answers at once. Otherwise the block reads the first and last
// knot, scans the table one knot at a time to find the enclosing interval if the query
// lies between them, and loads three or four knots. Every Lagrange term is then formed
// exactly in 128 bits on one shared unit: a shift-add multiplier, an adder and a
// restoring divider all use the same 128-bit adder. The input side is not ready while
// a query is in work. A finished result sits in an output register, so the next
// transfer is taken while it waits.
module lagrange_interp_nonuniform import lgi_pkg::*; #(
    parameter int MAX_KNOTS = LGI_MAX_KNOTS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lgi_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output lgi_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data
);

`include "lagrange_interp_nonuniform_assert.svh"

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);

    typedef enum logic [17:0] {
        S_IDLE = 18'd1 << 0,
        S_RD0  = 18'd1 << 1,
        S_RDN  = 18'd1 << 2,
        S_SCAN = 18'd1 << 3,
        S_PICK = 18'd1 << 4,
        S_LOAD = 18'd1 << 5,
        S_LDW  = 18'd1 << 6,
        S_TERM = 18'd1 << 7,
        S_MCHK = 18'd1 << 8,
        S_PJ   = 18'd1 << 9,
        S_PMW  = 18'd1 << 10,
        S_ADDW = 18'd1 << 11,
        S_DEN  = 18'd1 << 12,
        S_DMW  = 18'd1 << 13,
        S_VW   = 18'd1 << 14,
        S_QW   = 18'd1 << 15,
        S_FIN  = 18'd1 << 16,
        S_OUT  = 18'd1 << 17
    } state_e;

    state_e state_reg, state_next;
    logic [6:0]        knot_count_reg, knot_count_next;
    logic              m_valid_reg, m_valid_next;
    lgi_out_t          m_data_reg, m_data_next;

    logic signed [31:0] x_reg, x_next;
    logic               ord_reg, ord_next;
    logic [NW-1:0]      n_reg, n_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      first_reg, first_next;
    logic               use4_reg, use4_next;
    logic signed [31:0] kp_reg [4];
    logic signed [31:0] kp_next [4];
    logic signed [31:0] kv_reg [4];
    logic signed [31:0] kv_next [4];
    logic [2:0]         k_reg, k_next;
    logic [2:0]         m_reg, m_next;
    logic [2:0]         j_reg, j_next;
    logic [WIDE_W-1:0]  p_reg, p_next;
    logic [WIDE_W-1:0]  num_reg, num_next;
    logic [WIDE_W-1:0]  den_reg, den_next;
    logic signed [QUO_W-1:0] sum_reg, sum_next;
    logic               sat_reg, sat_next;
    logic               zero_reg, zero_next;
    logic signed [31:0] res_reg, res_next;
    logic [1:0]         st_reg, st_next;

    logic [AW-1:0]      rd_addr;
    knot_entry_t        rd_entry;
    knot_entry_t        wr_entry;
    logic               wr_en;
    logic [NW-1:0]      n_clamp;
    logic [2:0]         npts;
    logic               s_xfer;
    logic               load_xfer;
    logic               alu_waiting;
    logic               bad_order_out;

    alu_cmd_t                alu_cmd;
    alu_sts_t                alu_sts;
    logic [WIDE_W-1:0]       alu_opa, alu_opd, alu_prod;
    logic signed [FAC_W-1:0] alu_fac;
    logic signed [QUO_W-1:0] alu_quot;
    logic signed [FAC_W-1:0] dx_j, kdiff, kv_k;

    assign s_ready   = state_reg == S_IDLE;
    assign s_xfer    = s_valid && s_ready;
    assign load_xfer = s_xfer && (s_data.req_type == REQ_LOAD);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign npts      = use4_reg ? PTS4 : PTS3;

    // States in which the sequencer waits for the shared unit to finish.
    assign alu_waiting = (state_reg == S_PMW) || (state_reg == S_ADDW)
                      || (state_reg == S_DMW) || (state_reg == S_VW)
                      || (state_reg == S_QW);
    assign bad_order_out = m_valid && (m_data.status == ST_BAD_ORDER);

    // Loads to slots past the table are dropped.
    assign wr_en = load_xfer && (32'(s_data.knot_slot) < 32'(MAX_KNOTS));
    assign wr_entry.pos = s_data.knot_pos;
    assign wr_entry.val = s_data.knot_val;

    // Terms are built from differences of 32-bit positions, so 33 bits hold them.
    assign dx_j  = {x_reg[31], x_reg} - {kp_reg[j_reg[1:0]][31], kp_reg[j_reg[1:0]]};
    assign kdiff = {kp_reg[k_reg[1:0]][31], kp_reg[k_reg[1:0]]}
                 - {kp_reg[j_reg[1:0]][31], kp_reg[j_reg[1:0]]};
    assign kv_k  = {kv_reg[k_reg[1:0]][31], kv_reg[k_reg[1:0]]};

    always_comb begin
        if (knot_count_reg < 7'(MIN_KNOTS)) begin
            n_clamp = NW'(MIN_KNOTS);
        end else if (32'(knot_count_reg) > 32'(MAX_KNOTS)) begin
            n_clamp = NW'(MAX_KNOTS);
        end else begin
            n_clamp = NW'(knot_count_reg);
        end
    end

    lgi_knot_mem #(
        .MAX_KNOTS (MAX_KNOTS),
        .AW        (AW)
    ) u_mem (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.knot_slot)),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    lgi_alu u_alu (
        .clk  (aclk),
        .rstn (aresetn),
        .cmd  (alu_cmd),
        .opa  (alu_opa),
        .fac  (alu_fac),
        .opd  (alu_opd),
        .sts  (alu_sts),
        .prod (alu_prod),
        .quot (alu_quot)
    );

    // Sequencer. Term k is knot value k times numerator / denominator; the numerator is a sum
    // over passes m of products of (x - x_j); a value query makes one pass (m equal to k), a
    // slope query makes one pass for every m other than k and scales the sum by 2^16.
    always_comb begin
        state_next      = state_reg;
        knot_count_next = cfg_wr_en ? cfg_wr_data : knot_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        x_next     = x_reg;
        ord_next   = ord_reg;
        n_next     = n_reg;
        prev_next  = prev_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        first_next = first_reg;
        use4_next  = use4_reg;
        kp_next    = kp_reg;
        kv_next    = kv_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        sum_next   = sum_reg;
        sat_next   = sat_reg;
        zero_next  = zero_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        rd_addr    = '0;
        alu_cmd.start = 1'b0;
        alu_cmd.op    = OP_MUL;
        alu_opa    = p_reg;
        alu_fac    = dx_j;
        alu_opd    = p_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_data.req_type == REQ_QUERY)) begin
                    if (s_data.deriv_order[1]) begin
                        res_next   = '0;
                        st_next    = ST_BAD_ORDER;
                        state_next = S_OUT;
                    end else begin
                        x_next     = s_data.query_pos;
                        ord_next   = s_data.deriv_order[0];
                        n_next     = n_clamp;
                        found_next = 1'b0;
                        sum_next   = '0;
                        sat_next   = 1'b0;
                        zero_next  = 1'b0;
                        state_next = S_RD0;
                    end
                end
            end
            S_RD0: begin
                prev_next  = rd_entry.pos;
                rd_addr    = AW'(n_reg - NW'(1));
                state_next = S_RDN;
            end
            S_RDN: begin
                j_next = '0;
                if (x_reg < prev_reg) begin
                    first_next = '0;
                    use4_next  = 1'b0;
                    state_next = S_LOAD;
                end else if (x_reg >= rd_entry.pos) begin
                    first_next = AW'(n_reg - NW'(3));
                    use4_next  = 1'b0;
                    state_next = S_LOAD;
                end else begin
                    i_next     = AW'(1);
                    rd_addr    = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // The last interval that holds x wins.
                if ((x_reg >= prev_reg) && (x_reg < rd_entry.pos)) begin
                    idx_next   = i_reg - AW'(1);
                    found_next = 1'b1;
                end
                prev_next = rd_entry.pos;
                if (i_reg == AW'(n_reg - NW'(1))) begin
                    state_next = S_PICK;
                end else begin
                    i_next  = i_reg + AW'(1);
                    rd_addr = i_reg + AW'(1);
                end
            end
            S_PICK: begin
                j_next    = '0;
                use4_next = found_reg && (idx_reg != '0)
                         && (idx_reg != AW'(n_reg - NW'(2)));
                if (!found_reg || (idx_reg == '0)) begin
                    first_next = '0;
                end else if (idx_reg == AW'(n_reg - NW'(2))) begin
                    first_next = AW'(n_reg - NW'(3));
                end else begin
                    first_next = idx_reg - AW'(1);
                end
                state_next = S_LOAD;
            end
            S_LOAD: begin
                rd_addr    = first_reg + AW'(j_reg);
                state_next = S_LDW;
            end
            S_LDW: begin
                kp_next[j_reg[1:0]] = rd_entry.pos;
                kv_next[j_reg[1:0]] = rd_entry.val;
                if (j_reg == npts - 3'd1) begin
                    k_next     = '0;
                    state_next = S_TERM;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_LOAD;
                end
            end
            S_TERM: begin
                if (k_reg == npts) begin
                    state_next = S_FIN;
                end else begin
                    num_next   = '0;
                    m_next     = '0;
                    state_next = S_MCHK;
                end
            end
            S_MCHK: begin
                if (m_reg == npts) begin
                    if (ord_reg) begin
                        num_next = {num_reg[WIDE_W-17:0], 16'h0000};
                    end
                    den_next   = WIDE_W'(1);
                    j_next     = '0;
                    state_next = S_DEN;
                end else if (ord_reg ? (m_reg != k_reg) : (m_reg == k_reg)) begin
                    p_next     = WIDE_W'(1);
                    j_next     = '0;
                    state_next = S_PJ;
                end else begin
                    m_next = m_reg + 3'd1;
                end
            end
            S_PJ: begin
                if (j_reg == npts) begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = OP_ADD;
                    alu_opa       = num_reg;
                    alu_opd       = p_reg;
                    state_next    = S_ADDW;
                end else if ((j_reg == k_reg) || (j_reg == m_reg)) begin
                    j_next = j_reg + 3'd1;
                end else begin
                    alu_cmd.start = 1'b1;
                    alu_opa       = p_reg;
                    alu_fac       = dx_j;
                    state_next    = S_PMW;
                end
            end
            S_PMW: begin
                if (alu_sts.done) begin
                    p_next     = alu_prod;
                    j_next     = j_reg + 3'd1;
                    state_next = S_PJ;
                end
            end
            S_ADDW: begin
                if (alu_sts.done) begin
                    num_next   = alu_prod;
                    m_next     = m_reg + 3'd1;
                    state_next = S_MCHK;
                end
            end
            S_DEN: begin
                if (j_reg == npts) begin
                    alu_cmd.start = 1'b1;
                    alu_opa       = num_reg;
                    alu_fac       = kv_k;
                    state_next    = S_VW;
                end else if (j_reg == k_reg) begin
                    j_next = j_reg + 3'd1;
                end else begin
                    alu_cmd.start = 1'b1;
                    alu_opa       = den_reg;
                    alu_fac       = kdiff;
                    state_next    = S_DMW;
                end
            end
            S_DMW: begin
                if (alu_sts.done) begin
                    den_next   = alu_prod;
                    j_next     = j_reg + 3'd1;
                    state_next = S_DEN;
                end
            end
            S_VW: begin
                if (alu_sts.done) begin
                    num_next = alu_prod;
                    if (den_reg == '0) begin
                        // Two knots share a position: the term is skipped and flagged.
                        zero_next  = 1'b1;
                        k_next     = k_reg + 3'd1;
                        state_next = S_TERM;
                    end else begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = OP_DIV;
                        alu_opa       = alu_prod;
                        alu_opd       = den_reg;
                        state_next    = S_QW;
                    end
                end
            end
            S_QW: begin
                if (alu_sts.done) begin
                    sum_next   = sum_reg + alu_quot;
                    sat_next   = sat_reg | alu_sts.sat;
                    k_next     = k_reg + 3'd1;
                    state_next = S_TERM;
                end
            end
            S_FIN: begin
                if (zero_reg) begin
                    res_next = '0;
                    st_next  = ST_SAT;
                end else if (sum_reg > RES_MAX) begin
                    res_next = RES_MAX[31:0];
                    st_next  = ST_SAT;
                end else if (sum_reg < RES_MIN) begin
                    res_next = RES_MIN[31:0];
                    st_next  = ST_SAT;
                end else begin
                    res_next = sum_reg[31:0];
                    st_next  = sat_reg ? ST_SAT : ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.interp_result = res_reg;
                    m_data_next.status        = st_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            knot_count_reg <= 7'(MIN_KNOTS);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            knot_count_reg <= knot_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        x_reg      <= x_next;
        ord_reg    <= ord_next;
        n_reg      <= n_next;
        prev_reg   <= prev_next;
        i_reg      <= i_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        first_reg  <= first_next;
        use4_reg   <= use4_next;
        kp_reg     <= kp_next;
        kv_reg     <= kv_next;
        k_reg      <= k_next;
        m_reg      <= m_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        sum_reg    <= sum_next;
        sat_reg    <= sat_next;
        zero_reg   <= zero_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
    end

    `LGI_ASSERT_IMP(a_alu_done_waited, aclk, aresetn, alu_sts.done, alu_waiting)
    `LGI_ASSERT_NXT(a_load_stays_idle, aclk, aresetn, load_xfer, state_reg == S_IDLE)
    `LGI_ASSERT_IMP(a_bad_order_zero, aclk, aresetn, bad_order_out, m_data.interp_result == '0)
    `LGI_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_data.status <= ST_SAT)

endmodule

// ===== test/lgi_checker.sv =====
// Result checker for the Lagrange interpolator: tracks transfers and compares answers.
`timescale 1ns / 1ps
module lgi_checker import lgi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  lgi_in_t    s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  lgi_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    output int         fail_count,
    output int         answers_due
);

    logic signed [31:0] knot_x [LGI_MAX_KNOTS];
    logic signed [31:0] knot_y [LGI_MAX_KNOTS];
    logic [6:0]         knot_cnt;
    lgi_out_t           expected_answers [$];

    // Sum of rounded Lagrange terms over npts knots starting at first.
    function automatic lgi_out_t lagrange_eval(logic signed [31:0] x, int first, int npts,
                                               int order);
        logic signed [127:0] dxv [4];
        logic signed [127:0] num, den, p;
        logic [127:0]        nm, dm, q, rm;
        longint              sum, xk;
        bit                  sat, zero, ng;
        lgi_out_t            r;
        sum = 0;
        sat = 0;
        zero = 0;
        for (int j = 0; j < npts; j++) begin
            xk = longint'(x) - longint'(knot_x[first + j]);
            dxv[j] = xk;
        end
        for (int k = 0; k < npts; k++) begin
            if (order == 0) begin
                num = 1;
                for (int j = 0; j < npts; j++)
                    if (j != k) num = num * dxv[j];
            end else begin
                num = 0;
                for (int m = 0; m < npts; m++) begin
                    if (m == k) continue;
                    p = 1;
                    for (int j = 0; j < npts; j++)
                        if (j != k && j != m) p = p * dxv[j];
                    num = num + p;
                end
                num = num * 128'sd65536;
            end
            den = 1;
            for (int j = 0; j < npts; j++)
                if (j != k) begin
                    xk = longint'(knot_x[first + k]) - longint'(knot_x[first + j]);
                    p = xk;
                    den = den * p;
                end
            if (den == 0) begin
                zero = 1;
                continue;
            end
            p = knot_y[first + k];
            num = num * p;
            ng = num[127] ^ den[127];
            nm = num[127] ? -num : num;
            dm = den[127] ? -den : den;
            q = nm / dm;
            rm = nm % dm;
            if (rm >= dm - rm) q = q + 1;
            if (q > (128'h1 << 60)) begin
                q = 128'h1 << 60;
                sat = 1;
            end
            sum += ng ? -longint'(q[63:0]) : longint'(q[63:0]);
        end
        if (zero) begin
            r.interp_result = '0;
            r.status = ST_SAT;
            return r;
        end
        if (sum > 64'sh7FFF_FFFF) begin
            sum = 64'sh7FFF_FFFF;
            sat = 1;
        end
        if (sum < -64'sh8000_0000) begin
            sum = -64'sh8000_0000;
            sat = 1;
        end
        r.interp_result = sum[31:0];
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic lgi_out_t predict_answer(lgi_in_t item);
        int       n, first, idx;
        bit       found;
        lgi_out_t r;
        logic signed [31:0] x;
        if (item.deriv_order > 1) begin
            r.interp_result = '0;
            r.status = ST_BAD_ORDER;
            return r;
        end
        n = knot_cnt;
        if (n < MIN_KNOTS) n = MIN_KNOTS;
        if (n > LGI_MAX_KNOTS) n = LGI_MAX_KNOTS;
        x = item.query_pos;
        found = 0;
        idx = 0;
        if (x < knot_x[0]) begin
            first = 0;
        end else if (x >= knot_x[n-1]) begin
            first = n - 3;
        end else begin
            for (int i = 0; i + 1 < n; i++)
                if (x >= knot_x[i] && x < knot_x[i+1]) begin
                    idx = i;
                    found = 1;
                end
            if (!found || idx == 0) first = 0;
            else if (idx == n - 2) first = n - 3;
            else first = idx - 1;
        end
        if (found && idx != 0 && idx != n - 2)
            return lagrange_eval(x, first, 4, item.deriv_order);
        return lagrange_eval(x, first, 3, item.deriv_order);
    endfunction

    always @(posedge aclk) begin
        lgi_out_t want;
        if (!aresetn) begin
            knot_cnt = 7'd3;
            expected_answers.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) knot_cnt = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_LOAD) begin
                    knot_x[s_data.knot_slot] = s_data.knot_pos;
                    knot_y[s_data.knot_slot] = s_data.knot_val;
                end else begin
                    expected_answers.push_back(predict_answer(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result %h status %0d",
                                 m_data.interp_result, m_data.status);
                end else begin
                    want = expected_answers.pop_front();
                    if (want.interp_result !== m_data.interp_result ||
                        want.status !== m_data.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %h/%0d, got %h/%0d",
                                     want.interp_result, want.status,
                                     m_data.interp_result, m_data.status);
                    end
                end
            end
        end
        answers_due = expected_answers.size();
    end

endmodule

// ===== test/lagrange_interp_nonuniform_test.sv =====
// Top of the Lagrange interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module lagrange_interp_nonuniform_test import lgi_pkg::*;;

    // Bound on the run for roughly 1500 items and their stalls, taken with a wide margin.
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int     IN_W        = $bits(lgi_in_t);

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    lgi_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    lgi_out_t   m_data;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    int         fail_count;
    int         answers_due;
    longint     cycles = 0;

    // Shadow of the knot positions, used to load the table and to aim queries at the grid.
    logic signed [31:0] grid_x [LGI_MAX_KNOTS];
    int  active_knots = 3;
    bit  quiet = 0;        // when set, neither side idles
    bit  hold_results = 0; // asks the receiver for one long hold-off

    lagrange_interp_nonuniform u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    lgi_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .answers_due(answers_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The run ends here if the block stops making progress.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: a random wait before each transfer, and one long hold-off on request
    // so that the output register fills and the input side has to stall.
    initial begin
        int wait_cycles;
        @(posedge aresetn);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (6000) @(posedge aclk);
                hold_results = 0;
            end
            wait_cycles = quiet ? 0 : $urandom_range(0, 3);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Offers one transfer. Valid stays high into the next item when there is no gap,
    // so it is never lowered and raised within the same step.
    task automatic send_item(lgi_in_t item);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits until the checker has seen every answer. It first waits for the clock so that the
    // count already holds a query taken at the edge just before.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (answers_due == 0);
    endtask

    function automatic lgi_in_t knot_item(int slot, logic [31:0] xpos, logic [31:0] yval);
        lgi_in_t r;
        r = IN_W'({$urandom, $urandom, $urandom, $urandom});
        r.req_type  = REQ_LOAD;
        r.knot_slot = slot[5:0];
        r.knot_pos  = xpos;
        r.knot_val  = yval;
        return r;
    endfunction

    function automatic lgi_in_t query_item(logic [31:0] xpos, logic [1:0] order);
        lgi_in_t r;
        r = IN_W'({$urandom, $urandom, $urandom, $urandom});
        r.req_type    = REQ_QUERY;
        r.query_pos   = xpos;
        r.deriv_order = order;
        return r;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Waits until the block is drained, then writes the knot count.
    task automatic set_knot_count(logic [6:0] value);
        wait_drained();
        repeat (50) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_knots = value < 3 ? 3 : (value > 64 ? 64 : value);
    endtask

    // Loads a table of count knots. Shapes: 0 fine increasing, 1 increasing across the
    // whole range, 2 increasing with repeated positions, 3 unordered.
    task automatic load_table(int shape, int count);
        longint xk, span;
        logic [31:0] yv;
        span = 64'h1_0000_0000 / count - 1;
        xk = (shape == 1) ? -64'sh8000_0000 + $urandom_range(0, 1000)
                          : longint'($signed($urandom_range(0, 32'h0020_0000))) - 64'h10_0000;
        for (int i = 0; i < count; i++) begin
            case (shape)
                0: xk += $urandom_range(1, 32'h0004_0000);
                1: xk += $urandom_range(1, span);
                2: xk += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h0002_0000);
                default: xk = longint'($signed($urandom));
            endcase
            if (i == 0 && shape == 1) xk = -64'sh8000_0000;
            yv = (shape == 0) ? {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000 : $urandom;
            grid_x[i] = clamp32(xk);
            send_item(knot_item(i, grid_x[i], yv));
        end
    endtask

    // Picks a query position near the active grid, on a knot, outside it, or anywhere.
    function automatic logic [31:0] pick_position();
        longint lo, hi;
        int     pick;
        lo = grid_x[0];
        hi = grid_x[active_knots-1];
        pick = $urandom_range(0, 99);
        if (pick < 45 && hi > lo)
            return clamp32(lo + longint'({$urandom, $urandom} % (hi - lo)));
        if (pick < 60) return grid_x[$urandom_range(0, active_knots-1)];
        if (pick < 70) return clamp32(lo - $urandom_range(1, 32'h0010_0000));
        if (pick < 80) return clamp32(hi + $urandom_range(0, 32'h0010_0000));
        if (pick < 95) return $urandom;
        return pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic logic [1:0] pick_order();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9) return 2'd0;
        if (pick < 18) return 2'd1;
        return pick[0] ? 2'd3 : 2'd2;
    endfunction

    initial begin
        logic [6:0] count_plan [12];
        int         shape;
        count_plan = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd4, 7'd5,
                       7'd64, 7'd10, 7'd3, 7'd32};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot once so that any clamped knot count reads written entries.
        set_knot_count(count_plan[0]);
        load_table(0, 64);

        // Directed part on a three-knot grid: both rejected orders, and each order below
        // the grid, on every knot, above it, and at the extremes of the position range.
        send_item(query_item($urandom, 2'd2));
        send_item(query_item($urandom, 2'd3));
        for (int ord = 0; ord < 2; ord++) begin
            send_item(query_item(grid_x[0] - 1, ord[1:0]));
            for (int i = 0; i < 3; i++) send_item(query_item(grid_x[i], ord[1:0]));
            send_item(query_item(grid_x[2] + 32'h0008_0000, ord[1:0]));
            send_item(query_item(32'h8000_0000, ord[1:0]));
            send_item(query_item(32'h7FFF_FFFF, ord[1:0]));
        end

        for (int phase = 0; phase < 12; phase++) begin
            if (phase != 0) begin
                set_knot_count(count_plan[phase]);
                shape = phase % 4;
                load_table(shape, active_knots);
            end
            quiet = (phase % 5 == 3);
            if (phase == 1) hold_results = 1;
            for (int q = 0; q < 100; q++) begin
                // Now and then rewrite one knot in the middle of the queries.
                if ($urandom_range(0, 19) == 0) begin
                    int slot;
                    slot = $urandom_range(0, active_knots - 1);
                    grid_x[slot] = (slot == 0) ? grid_x[0] - 1 : grid_x[slot];
                    send_item(knot_item(slot, grid_x[slot], $urandom));
                end
                send_item(query_item(pick_position(), pick_order()));
                // One pause on the input side until every answer is back.
                if (phase == 6 && q == 50) begin
                    wait_drained();
                    @(posedge aclk);
                end
            end
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
